@@ design/iss_pkg.sv @@
// Shared types for the insertion sorter: item and result structs and the
// control word handed from the top level to every cell.
// No dependencies.
package iss_pkg;

  localparam int unsigned SAMPLE_W = 32;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_run;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sorted_value;
    logic                       final_res;
    logic                       overflowed;
  } result_t;

  typedef struct packed {
    logic load;
    logic drain;
  } cell_ctl_t;

endpackage

@@ design/iss_cell.sv @@
// One cell of the sorting chain: holds one value, compares it with the
// broadcast key and takes the key or a neighbour's value. Depends on iss_pkg.
module iss_cell
  import iss_pkg::*;
(
  input  logic                       clk,
  input  cell_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] key,
  input  logic                       occ,
  input  logic                       left_ins,
  input  logic signed [SAMPLE_W-1:0] left_val,
  input  logic signed [SAMPLE_W-1:0] right_val,
  output logic                       ins,
  output logic signed [SAMPLE_W-1:0] val
);

  assign ins = !occ || (key < val);

  always_ff @(posedge clk) begin
    if (ctl.load && ins) begin
      val <= left_ins ? left_val : key;
    end else if (ctl.drain) begin
      val <= right_val;
    end
  end

endmodule

@@ design/insertion_sorter.sv @@
// Insertion sorter: a chain of CAPACITY cells keeps the run in ascending
// order; each item is inserted in the cycle it is accepted, so a new item
// can be taken every cycle while busy is low. The item flagged end_of_run
// is inserted and the block then raises busy and shifts the chain out
// through its first cell, one result per cycle on strobe, one for each
// value stored (1 to CAPACITY); busy falls after the last one, which
// carries final_res. Results cannot be held off by the receiver.
// Values arriving while the chain is full are dropped and the run's results
// carry overflowed. Depends on iss_pkg and iss_cell.
module insertion_sorter
  import iss_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] remaining;
  logic          ovf;

  logic          accept;
  logic          full;
  logic          store;
  cell_ctl_t     ctl;

  logic signed [SAMPLE_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]        ins;
  logic [CAPACITY-1:0]        occ;

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign store  = accept && !full;

  assign ctl.load  = store;
  assign ctl.drain = busy;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                       l_ins;
      logic signed [SAMPLE_W-1:0] l_val;
      logic signed [SAMPLE_W-1:0] r_val;

      assign occ[i] = (CW'(i) < count);

      if (i == 0) begin : g_first
        assign l_ins = 1'b0;
        assign l_val = item.sample;
      end else begin : g_mid
        assign l_ins = ins[i-1];
        assign l_val = vals[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign r_val = vals[i];
      end else begin : g_inner
        assign r_val = vals[i+1];
      end

      iss_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .key       (item.sample),
        .occ       (occ[i]),
        .left_ins  (l_ins),
        .left_val  (l_val),
        .right_val (r_val),
        .ins       (ins[i]),
        .val       (vals[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      count     <= '0;
      remaining <= '0;
      ovf       <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (accept) begin
            if (full) begin
              ovf <= 1'b1;
            end
            if (item.end_of_run) begin
              remaining <= store ? count + CW'(1) : count;
              count     <= '0;
              state     <= ST_DRAIN;
            end else if (store) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_DRAIN: begin
          remaining <= remaining - CW'(1);
          if (remaining == CW'(1)) begin
            ovf   <= 1'b0;
            state <= ST_FILL;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  assign strobe              = busy;
  assign result.sorted_value = vals[0];
  assign result.final_res    = (remaining == CW'(1));
  assign result.overflowed   = ovf;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for insertion_sorter: drives runs of signed items
// over the start/busy handshake and checks every strobed result against a
// built-in insertion predictor. Depends on iss_pkg and the sorter RTL.
`timescale 1ns / 1ps

module tb_top;
  import iss_pkg::*;

  localparam int unsigned CAP        = 64;
  localparam int          STALL_LIMIT = 2000;
  localparam int          MAX_REPORTS = 40;
  localparam int          RANDOM_ITEMS = 140;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  logic signed [SAMPLE_W-1:0] sorted_copy [CAP];
  int unsigned                stored_count;
  logic                       dropped_in_run;
  result_t                    pending_sorted[$];

  int  error_count;
  int  stall_cycles;
  bit  calm;
  bit  took_item;

  insertion_sorter #(
    .CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // insert one item into the predicted store; queue the sorted run on its last item
  task automatic insert_and_emit(input item_t it);
    int unsigned pos;
    result_t     r;
    if (stored_count < CAP) begin
      pos = stored_count;
      while (pos > 0 && $signed(it.sample) < sorted_copy[pos-1]) begin
        sorted_copy[pos] = sorted_copy[pos-1];
        pos--;
      end
      sorted_copy[pos] = it.sample;
      stored_count++;
    end else begin
      dropped_in_run = 1'b1;
    end
    if (it.end_of_run) begin
      for (int unsigned k = 0; k < stored_count; k++) begin
        r.sorted_value = sorted_copy[k];
        r.final_res    = (k + 1 == stored_count);
        r.overflowed   = dropped_in_run;
        pending_sorted.push_back(r);
      end
      stored_count   = 0;
      dropped_in_run = 1'b0;
    end
  endtask

  task automatic report_error(input string what, input result_t want, input result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t ns: %s expected value=%0d final=%b ovf=%b, actual value=%0d final=%b ovf=%b",
               $realtime, what, $signed(want.sorted_value), want.final_res, want.overflowed,
               $signed(got.sorted_value), got.final_res, got.overflowed);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      took_item = start && !busy;
      if (took_item)
        insert_and_emit(item);
      if (strobe) begin
        if (pending_sorted.size() == 0) begin
          report_error("unexpected result:", '0, result);
        end else begin
          if (result.sorted_value !== pending_sorted[0].sorted_value ||
              result.final_res !== pending_sorted[0].final_res ||
              result.overflowed !== pending_sorted[0].overflowed)
            report_error("result mismatch:", pending_sorted[0], result);
          void'(pending_sorted.pop_front());
        end
      end
      if (took_item || strobe)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // hold start high until the item is taken; idle now and then beforehand
  task automatic send_item(input logic signed [SAMPLE_W-1:0] value, input logic last);
    item_t it;
    it.sample     = value;
    it.end_of_run = last;
    if (!calm && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_run(input int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      send_item(pick_sample(), k + 1 == len);
  endtask

  task automatic test_single_values();
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b1);
    send_item(32'sd0, 1'b1);
  endtask

  task automatic test_extremes_and_ties();
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b1);
    for (int k = 0; k < 6; k++)
      send_item(32'sd40 - k * 7, k == 5);
  endtask

  task automatic test_store_full();
    send_run(CAP);
    send_run(CAP + 1);
    send_run(CAP + 6);
    send_run(CAP - 1);
  endtask

  task automatic test_random_runs();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 10);
      else if (pick < 90) len = $urandom_range(11, 40);
      else if (pick < 96) len = $urandom_range(41, CAP);
      else                len = $urandom_range(CAP + 1, CAP + 10);
      calm = (sent >= 20 && sent < 100);
      send_run(len);
      sent += len;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    item           = '0;
    error_count    = 0;
    stall_cycles   = 0;
    calm           = 1'b0;
    stored_count   = 0;
    dropped_in_run = 1'b0;
    foreach (sorted_copy[k]) sorted_copy[k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_values();
    test_extremes_and_ties();
    test_store_full();
    test_random_runs();

    start <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/iss_pkg.sv
design/iss_cell.sv
design/insertion_sorter.sv
sim/tb_top.sv
